### rtl/apsq_pkg.sv
package apsq_pkg;

    localparam int RING_SLOTS        = 64;
    localparam int MAX_PACKET_FRAMES = 256;
    localparam int MAX_BLOCK_FRAMES  = 4096;

    localparam int PTR_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RING_SLOTS + 1);
    localparam int PF_W       = $clog2(MAX_PACKET_FRAMES + 1);
    localparam int FRAMES_W   = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int REM_W      = PF_W + 1;
    localparam int DIV_STEP_W = $clog2(FRAMES_W + 1);

    localparam int SEQ_W   = 32;
    localparam int POS_W   = 64;
    localparam int TOT_W   = 32;
    localparam int DROPF_W = 48;

    localparam int PF_REG_W    = 9;
    localparam int SLOTS_REG_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = 2'd1;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [POS_W-1:0] pos;
        logic [PF_W-1:0]  len;
        logic             silence;
    } t_slot;

    typedef struct packed {
        logic load;
        logic div_start;
        logic refuse;
        logic empty_pop;
        logic rd;
        logic pop_commit;
        logic drop;
        logic admit;
        logic wr;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic bad_size;
        logic empty;
        logic div_done;
        logic fits;
        logic last;
    } t_dp_status;

endpackage

### rtl/apsq_div.sv
module apsq_div import apsq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [FRAMES_W-1:0] i_dividend,
    input  logic [PF_W-1:0]     i_divisor,
    output logic                o_done,
    output logic [FRAMES_W-1:0] o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [FRAMES_W-1:0]   r_num;
    logic [REM_W-1:0]      r_rem;
    logic [PF_W-1:0]       r_div;

    logic [REM_W-1:0] shifted;
    logic             take;
    logic [REM_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem[REM_W-2:0], r_num[FRAMES_W-1]};
        take    = (shifted >= REM_W'(r_div));
        n_rem   = take ? (shifted - REM_W'(r_div)) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_num  <= {r_num[FRAMES_W-2:0], take};
                r_rem  <= n_rem;
                r_step <= r_step + DIV_STEP_W'(1);
                if (r_step == DIV_STEP_W'(FRAMES_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

### rtl/apsq_dp.sv
module apsq_dp import apsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_opcode,
    input  logic [FRAMES_W-1:0]   i_block_frames,
    input  logic                  i_silence_flag,
    output logic                  o_accepted,
    output logic                  o_pkt_found,
    output logic [SEQ_W-1:0]      o_sequence_number,
    output logic [POS_W-1:0]      o_frame_position,
    output logic [PF_W-1:0]       o_chunk_len,
    output logic                  o_chunk_silence,
    output logic [FRAMES_W-1:0]   o_packets_made,
    output logic [CNT_W-1:0]      o_queue_depth,
    output logic [TOT_W-1:0]      o_drop_pkt_count,
    output logic [DROPF_W-1:0]    o_drop_frame_count,
    output logic [TOT_W-1:0]      o_enq_count,
    output logic [TOT_W-1:0]      o_deq_count
);

    logic [PF_REG_W-1:0]    r_packet_frames;
    logic [SLOTS_REG_W-1:0] r_slots_in_use;
    logic [SEQ_W-1:0]       r_next_seq;
    logic [POS_W-1:0]       r_next_pos;
    logic [PTR_W-1:0]       r_wp;
    logic [PTR_W-1:0]       r_rp;
    logic [CNT_W-1:0]       r_held;
    logic [TOT_W-1:0]       r_drop_pkts;
    logic [DROPF_W-1:0]     r_drop_frames;
    logic [TOT_W-1:0]       r_enq;
    logic [TOT_W-1:0]       r_deq;

    logic                r_op;
    logic [FRAMES_W-1:0] r_frames;
    logic                r_silence;
    logic [FRAMES_W-1:0] r_remaining;
    logic [FRAMES_W-1:0] r_left;

    t_slot r_mem [RING_SLOTS];
    t_slot r_rdata;

    logic                r_res_accepted;
    logic                r_res_avail;
    logic [SEQ_W-1:0]    r_res_seq;
    logic [POS_W-1:0]    r_res_pos;
    logic [PF_W-1:0]     r_res_chunk;
    logic                r_res_silence;
    logic [FRAMES_W-1:0] r_res_made;

    logic [PF_W-1:0]     pf_eff;
    logic [CNT_W-1:0]    cap_eff;
    logic [CNT_W-1:0]    room;
    logic [FRAMES_W-1:0] count;
    logic [FRAMES_W-1:0] dividend;
    logic [PF_W-1:0]     chunk;
    logic                div_done;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(p) + CNT_W'(1);
        return (nxt == cap) ? '0 : nxt[PTR_W-1:0];
    endfunction

    always_comb begin
        if (r_packet_frames == '0) begin
            pf_eff = PF_W'(1);
        end else if (PF_W'(r_packet_frames) > PF_W'(MAX_PACKET_FRAMES)) begin
            pf_eff = PF_W'(MAX_PACKET_FRAMES);
        end else begin
            pf_eff = PF_W'(r_packet_frames);
        end
        if (r_slots_in_use == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CNT_W'(r_slots_in_use) > CNT_W'(RING_SLOTS)) begin
            cap_eff = CNT_W'(RING_SLOTS);
        end else begin
            cap_eff = CNT_W'(r_slots_in_use);
        end
        room     = cap_eff - r_held;
        dividend = r_frames + FRAMES_W'(pf_eff) - FRAMES_W'(1);
        chunk    = (r_left < FRAMES_W'(pf_eff)) ? r_left[PF_W-1:0] : pf_eff;
    end

    apsq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (pf_eff),
        .o_done     (div_done),
        .o_quotient (count)
    );

    always_comb begin
        o_status.op       = r_op;
        o_status.bad_size = (r_frames == '0) || (r_frames > FRAMES_W'(MAX_BLOCK_FRAMES));
        o_status.empty    = (r_held == '0);
        o_status.div_done = div_done;
        o_status.fits     = (count <= FRAMES_W'(room));
        o_status.last     = (r_remaining == FRAMES_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_frames <= PF_REG_W'(MAX_PACKET_FRAMES);
            r_slots_in_use  <= SLOTS_REG_W'(RING_SLOTS);
            r_next_seq      <= '0;
            r_next_pos      <= '0;
            r_wp            <= '0;
            r_rp            <= '0;
            r_held          <= '0;
            r_drop_pkts     <= '0;
            r_drop_frames   <= '0;
            r_enq           <= '0;
            r_deq           <= '0;
            r_remaining     <= '0;
        end else begin
            if (i_cmd.drop) begin
                r_next_seq    <= r_next_seq + SEQ_W'(count);
                r_next_pos    <= r_next_pos + POS_W'(r_frames);
                r_drop_pkts   <= r_drop_pkts + TOT_W'(count);
                r_drop_frames <= r_drop_frames + DROPF_W'(r_frames);
            end
            if (i_cmd.admit) begin
                r_held      <= r_held + count[CNT_W-1:0];
                r_enq       <= r_enq + TOT_W'(count);
                r_remaining <= count;
                r_left      <= r_frames;
            end
            if (i_cmd.wr) begin
                r_next_seq  <= r_next_seq + SEQ_W'(1);
                r_next_pos  <= r_next_pos + POS_W'(chunk);
                r_left      <= r_left - FRAMES_W'(chunk);
                r_remaining <= r_remaining - FRAMES_W'(1);
                r_wp        <= ptr_inc(r_wp, cap_eff);
            end
            if (i_cmd.pop_commit) begin
                r_rp   <= ptr_inc(r_rp, cap_eff);
                r_held <= r_held - CNT_W'(1);
                r_deq  <= r_deq + TOT_W'(1);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PACKET_FRAMES) begin
                    r_packet_frames <= i_cfg_data[PF_REG_W-1:0];
                end else if (i_cfg_index == CFG_SLOTS_IN_USE) begin
                    r_slots_in_use <= i_cfg_data[SLOTS_REG_W-1:0];
                    r_wp           <= '0;
                    r_rp           <= '0;
                    r_held         <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_opcode;
            r_frames  <= i_block_frames;
            r_silence <= i_silence_flag;
        end
        if (i_cmd.wr) begin
            r_mem[r_wp] <= '{seq: r_next_seq, pos: r_next_pos, len: chunk,
                             silence: r_silence};
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.refuse || i_cmd.empty_pop || i_cmd.drop || i_cmd.admit) begin
            r_res_accepted <= i_cmd.admit;
            r_res_avail    <= 1'b0;
            r_res_seq      <= i_cmd.empty_pop ? '0 : r_next_seq;
            r_res_pos      <= '0;
            r_res_chunk    <= '0;
            r_res_silence  <= 1'b0;
            r_res_made     <= (i_cmd.drop || i_cmd.admit) ? count : '0;
        end else if (i_cmd.pop_commit) begin
            r_res_accepted <= 1'b0;
            r_res_avail    <= 1'b1;
            r_res_seq      <= r_rdata.seq;
            r_res_pos      <= r_rdata.pos;
            r_res_chunk    <= r_rdata.len;
            r_res_silence  <= r_rdata.silence;
            r_res_made     <= '0;
        end
    end

    assign o_accepted         = r_res_accepted;
    assign o_pkt_found        = r_res_avail;
    assign o_sequence_number  = r_res_seq;
    assign o_frame_position   = r_res_pos;
    assign o_chunk_len        = r_res_chunk;
    assign o_chunk_silence    = r_res_silence;
    assign o_packets_made     = r_res_made;
    assign o_queue_depth      = r_held;
    assign o_drop_pkt_count   = r_drop_pkts;
    assign o_drop_frame_count = r_drop_frames;
    assign o_enq_count        = r_enq;
    assign o_deq_count        = r_deq;

    a_held_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= cap_eff)
        else $error("queue depth exceeds ring capacity");

    a_write_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> r_remaining != '0)
        else $error("descriptor write with no packet left");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> r_held != '0)
        else $error("slot read from an empty ring");

endmodule

### rtl/apsq_ctrl.sv
module apsq_ctrl import apsq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_idle,
    output logic       o_strobe
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_DIV      = 6'b000100,
        S_DECIDE   = 6'b001000,
        S_WRITE    = 6'b010000,
        S_READ     = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;
    logic   n_strobe;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.op == OP_POP) begin
                    if (i_status.empty) begin
                        o_cmd.empty_pop = 1'b1;
                        n_strobe        = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_READ;
                    end
                end else if (i_status.bad_size) begin
                    o_cmd.refuse = 1'b1;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.fits) begin
                    o_cmd.admit = 1'b1;
                    n_state     = S_WRITE;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_strobe   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                if (i_status.last) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.pop_commit = 1'b1;
                n_strobe         = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_idle   = (r_state == S_IDLE);
    assign o_strobe = r_strobe;

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == S_IDLE)
        else $error("result strobe while a request is still in progress");

endmodule

### rtl/audio_packet_segmenting_queue_top.sv
// Audio packet segmenting queue. A request is taken when i_start is high and
// o_busy is low: opcode 0 submits a block of frames, opcode 1 pops the oldest
// packet descriptor. Each request gives exactly one result, shown for a single
// cycle while o_result_valid is high; the receiver cannot hold it off, and the
// running counters and queue depth are stable during that cycle.
// A pop reads the oldest slot and then commits it; a refused submit is
// turned away at dispatch. A valid submit runs a restoring divider for the
// packet count, one quotient bit a cycle, then writes one descriptor a cycle
// into the slot memory when admitted, or drops the whole block when its
// packets do not fit in the free slots. A new request may be given in the
// cycle in which the previous result is strobed.
// Configuration writes use i_cfg_valid and o_cfg_ready with a register index
// and data; ready is high only while no request is in progress. Writing the
// slot count empties the ring. After reset both registers hold their largest
// values, the ring is empty and all counters are zero; no clearing pass runs.
module audio_packet_segmenting_queue_top import apsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_opcode,
    input  logic [FRAMES_W-1:0]   i_block_frames,
    input  logic                  i_silence_flag,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_valid,
    output logic                  o_accepted,
    output logic                  o_pkt_found,
    output logic [SEQ_W-1:0]      o_sequence_number,
    output logic [POS_W-1:0]      o_frame_position,
    output logic [PF_W-1:0]       o_chunk_len,
    output logic                  o_chunk_silence,
    output logic [FRAMES_W-1:0]   o_packets_made,
    output logic [CNT_W-1:0]      o_queue_depth,
    output logic [TOT_W-1:0]      o_drop_pkt_count,
    output logic [DROPF_W-1:0]    o_drop_frame_count,
    output logic [TOT_W-1:0]      o_enq_count,
    output logic [TOT_W-1:0]      o_deq_count
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       idle;

    assign o_cfg_ready = idle;

    apsq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_idle   (idle),
        .o_strobe (o_result_valid)
    );

    apsq_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_valid && idle),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_opcode           (i_opcode),
        .i_block_frames     (i_block_frames),
        .i_silence_flag     (i_silence_flag),
        .o_accepted         (o_accepted),
        .o_pkt_found        (o_pkt_found),
        .o_sequence_number  (o_sequence_number),
        .o_frame_position   (o_frame_position),
        .o_chunk_len        (o_chunk_len),
        .o_chunk_silence    (o_chunk_silence),
        .o_packets_made     (o_packets_made),
        .o_queue_depth      (o_queue_depth),
        .o_drop_pkt_count   (o_drop_pkt_count),
        .o_drop_frame_count (o_drop_frame_count),
        .o_enq_count        (o_enq_count),
        .o_deq_count        (o_deq_count)
    );

endmodule
